/* rtl/core/least_used_ratio_branch_select_core_macros.svh */
// ============================================================================
// Assertion macros for the least-used ratio branch selector
// Concurrent check wrappers that compile away when SYNTH is defined.
// ============================================================================
`ifndef LEAST_USED_RATIO_BRANCH_SELECT_CORE_MACROS_SVH
`define LEAST_USED_RATIO_BRANCH_SELECT_CORE_MACROS_SVH

`ifndef SYNTH
// Same-cycle implication, checked outside reset
`define LURB_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("lurb assertion failed");
// Next-cycle implication, checked outside reset
`define LURB_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("lurb assertion failed");
`else
`define LURB_ASSERT_NOW(label, ante, cons)
`define LURB_ASSERT_NEXT(label, ante, cons)
`endif

`endif

/* rtl/core/lurb_pkg.sv */
// ============================================================================
// lurb_pkg
// Shared types, constants and arithmetic helpers for the branch selector.
// ============================================================================
package lurb_pkg;

    localparam int MAX_BRANCHES_DEF = 64;
    localparam int BYTES_W          = 64;
    localparam int TOTAL_W          = 65;
    localparam int PROD_W           = 129;
    localparam int INDEX_W          = 6;
    localparam int HALF_W           = 32;

    // Policy kind of an item
    typedef enum logic [1:0] {
        MODE_ACTION = 2'd0,
        MODE_SEARCH = 2'd1,
        MODE_CREATE = 2'd2
    } t_mode;

    // Error codes, ordered by priority (larger wins)
    typedef enum logic [1:0] {
        ERR_NONE  = 2'd0,
        ERR_NOENT = 2'd1,
        ERR_ROFS  = 2'd2,
        ERR_NOSPC = 2'd3
    } t_err;

    // One filtered branch item
    typedef struct packed {
        logic                cons;   // branch takes part in the compare
        t_err                err;    // error noted by this item
        logic                last;   // item closes the run
        logic [BYTES_W-1:0]  used;   // normalized used bytes
        logic [TOTAL_W-1:0]  total;  // normalized total bytes
    } t_item;

    // Partial products of a 64 x 65 multiply
    typedef struct packed {
        logic [2*HALF_W-1:0] p00;
        logic [2*HALF_W-1:0] p01;
        logic [2*HALF_W-1:0] p10;
        logic [2*HALF_W-1:0] p11;
        logic [BYTES_W-1:0]  ext;    // used times the top total bit
    } t_xprod;

    // Both sides of a cross-multiplied fraction compare
    typedef struct packed {
        t_xprod lhs;
        t_xprod rhs;
    } t_xpair;

    // 64 x 65 product as four 32 x 32 partials plus the top-bit term
    function automatic t_xprod xprod(input logic [BYTES_W-1:0] u,
                                     input logic [TOTAL_W-1:0] t);
        t_xprod p;
        p.p00 = 64'(u[HALF_W-1:0])         * 64'(t[HALF_W-1:0]);
        p.p01 = 64'(u[HALF_W-1:0])         * 64'(t[2*HALF_W-1:HALF_W]);
        p.p10 = 64'(u[2*HALF_W-1:HALF_W])  * 64'(t[HALF_W-1:0]);
        p.p11 = 64'(u[2*HALF_W-1:HALF_W])  * 64'(t[2*HALF_W-1:HALF_W]);
        p.ext = t[TOTAL_W-1] ? u : '0;
        return p;
    endfunction

    // Sum the partials into the exact 129-bit product
    function automatic logic [PROD_W-1:0] fold(input t_xprod p);
        logic [PROD_W-1:0] s;
        s = PROD_W'(p.p00)
          + (PROD_W'(p.p01) << HALF_W)
          + (PROD_W'(p.p10) << HALF_W)
          + (PROD_W'(p.p11) << (2 * HALF_W))
          + (PROD_W'(p.ext) << (2 * HALF_W));
        return s;
    endfunction

endpackage

/* rtl/core/lurb_front.sv */
// ============================================================================
// lurb_front
// Input register: mode filters, total bytes and run position per item.
// ============================================================================
module lurb_front #(
    parameter int MAX_BRANCHES = lurb_pkg::MAX_BRANCHES_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_advance,
    input  logic                              i_valid,
    input  logic [1:0]                        i_mode,
    input  logic                              i_branch_readonly,
    input  logic                              i_branch_no_create,
    input  logic                              i_path_exists,
    input  logic                              i_stats_ok,
    input  logic                              i_fs_readonly,
    input  logic [lurb_pkg::BYTES_W-1:0]      i_space_used,
    input  logic [lurb_pkg::BYTES_W-1:0]      i_space_avail,
    input  logic [lurb_pkg::BYTES_W-1:0]      i_min_free_space,
    input  logic                              i_last_branch,
    output logic                              o_valid,
    output lurb_pkg::t_item                   o_item,
    output logic [$clog2(MAX_BRANCHES+1)-1:0] o_pos
);

    localparam int PW = $clog2(MAX_BRANCHES + 1);

    logic                   r_valid;
    logic [PW-1:0]          r_cnt;
    logic [PW-1:0]          r_pos;
    lurb_pkg::t_item        r_item;
    logic [PW-1:0]          n_cnt;
    lurb_pkg::t_item        n_item;
    logic                   accept;
    logic                   in_range;
    logic                   cons;
    lurb_pkg::t_err         err;
    logic [lurb_pkg::TOTAL_W-1:0] sum;

    assign accept   = i_valid && i_advance;
    assign in_range = r_cnt < PW'(MAX_BRANCHES);

    // Mode filters
    always_comb begin
        cons = 1'b0;
        err  = lurb_pkg::ERR_NONE;
        case (lurb_pkg::t_mode'(i_mode))
            lurb_pkg::MODE_ACTION: begin
                if (i_branch_readonly)   err  = lurb_pkg::ERR_ROFS;
                else if (!i_path_exists) err  = lurb_pkg::ERR_NOENT;
                else if (!i_stats_ok)    err  = lurb_pkg::ERR_NOENT;
                else if (i_fs_readonly)  err  = lurb_pkg::ERR_ROFS;
                else                     cons = 1'b1;
            end
            lurb_pkg::MODE_SEARCH: begin
                cons = i_path_exists && i_stats_ok;
            end
            lurb_pkg::MODE_CREATE: begin
                if (i_branch_readonly || i_branch_no_create) err = lurb_pkg::ERR_ROFS;
                else if (!i_stats_ok)                     err  = lurb_pkg::ERR_NOENT;
                else if (i_fs_readonly)                   err  = lurb_pkg::ERR_ROFS;
                else if (i_space_avail < i_min_free_space) err = lurb_pkg::ERR_NOSPC;
                else                                      cons = 1'b1;
            end
            default: begin
                cons = 1'b0;
            end
        endcase
        // items past the branch limit are ignored
        if (!in_range) begin
            cons = 1'b0;
            err  = lurb_pkg::ERR_NONE;
        end
    end

    // Total bytes; a zero total reads as 0/1
    assign sum = {1'b0, i_space_used} + {1'b0, i_space_avail};

    always_comb begin
        n_item.cons  = cons;
        n_item.err   = err;
        n_item.last  = i_last_branch;
        n_item.used  = i_space_used;
        n_item.total = sum;
        if (sum == '0) begin
            n_item.used  = '0;
            n_item.total = lurb_pkg::TOTAL_W'(1);
        end
    end

    // Run position, saturating at the limit, cleared after the last item
    always_comb begin
        n_cnt = r_cnt;
        if (accept) begin
            if (i_last_branch) n_cnt = '0;
            else if (in_range) n_cnt = r_cnt + PW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_cnt   <= '0;
        end else begin
            r_cnt <= n_cnt;
            if (i_advance) r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_item <= n_item;
            r_pos  <= r_cnt;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;
    assign o_pos   = r_pos;

endmodule

/* rtl/core/lurb_xmul.sv */
// ============================================================================
// lurb_xmul
// Cross-multiply stage: partial products against the running best and
// against the item one stage ahead, registered with the item.
// ============================================================================
module lurb_xmul #(
    parameter int MAX_BRANCHES = lurb_pkg::MAX_BRANCHES_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_advance,
    input  logic                              i_valid,
    input  lurb_pkg::t_item                   i_item,
    input  logic [$clog2(MAX_BRANCHES+1)-1:0] i_pos,
    input  logic [lurb_pkg::BYTES_W-1:0]      i_lead_used,
    input  logic [lurb_pkg::TOTAL_W-1:0]      i_lead_total,
    input  logic                              i_ahead_win,
    output logic                              o_valid,
    output lurb_pkg::t_item                   o_item,
    output logic [$clog2(MAX_BRANCHES+1)-1:0] o_pos,
    output lurb_pkg::t_xpair                  o_xb,
    output lurb_pkg::t_xpair                  o_xp,
    output logic                              o_use_prev
);

    localparam int PW = $clog2(MAX_BRANCHES + 1);

    logic              r_valid;
    lurb_pkg::t_item   r_item;
    logic [PW-1:0]     r_pos;
    lurb_pkg::t_xpair  r_xb;
    lurb_pkg::t_xpair  r_xp;
    logic              r_use_prev;
    lurb_pkg::t_xpair  n_xb;
    lurb_pkg::t_xpair  n_xp;

    // Candidate vs running best, candidate vs the item now resolving
    always_comb begin
        n_xb.lhs = lurb_pkg::xprod(i_item.used, i_lead_total);
        n_xb.rhs = lurb_pkg::xprod(i_lead_used, i_item.total);
        n_xp.lhs = lurb_pkg::xprod(i_item.used, r_item.total);
        n_xp.rhs = lurb_pkg::xprod(r_item.used, i_item.total);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= 1'b0;
            r_use_prev <= 1'b0;
        end else if (i_advance) begin
            r_valid    <= i_valid;
            // the item ahead becomes the best at this same edge
            r_use_prev <= r_valid && i_ahead_win;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_advance && i_valid) begin
            r_item <= i_item;
            r_pos  <= i_pos;
            r_xb   <= n_xb;
            r_xp   <= n_xp;
        end
    end

    assign o_valid    = r_valid;
    assign o_item     = r_item;
    assign o_pos      = r_pos;
    assign o_xb       = r_xb;
    assign o_xp       = r_xp;
    assign o_use_prev = r_use_prev;

endmodule

/* rtl/core/lurb_pick.sv */
// ============================================================================
// lurb_pick
// Resolve stage: exact fraction compare, running best, worst error and
// the result register.
// ============================================================================
`include "least_used_ratio_branch_select_core_macros.svh"

module lurb_pick #(
    parameter int MAX_BRANCHES = lurb_pkg::MAX_BRANCHES_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_s2_valid,
    input  lurb_pkg::t_item                   i_s2,
    input  logic [$clog2(MAX_BRANCHES+1)-1:0] i_s2_pos,
    input  lurb_pkg::t_xpair                  i_xb,
    input  lurb_pkg::t_xpair                  i_xp,
    input  logic                              i_use_prev,
    input  logic                              i_stall,
    output logic                              o_advance,
    output logic                              o_win,
    output logic [lurb_pkg::BYTES_W-1:0]      o_lead_used,
    output logic [lurb_pkg::TOTAL_W-1:0]      o_lead_total,
    output logic                              o_valid,
    output logic                              o_found,
    output logic [lurb_pkg::INDEX_W-1:0]      o_chosen_index,
    output logic [1:0]                        o_error_kind
);

    localparam int PW = $clog2(MAX_BRANCHES + 1);

    logic                           r_have_best;
    lurb_pkg::t_err                 r_worst;
    logic [lurb_pkg::BYTES_W-1:0]   r_lead_used;
    logic [lurb_pkg::TOTAL_W-1:0]   r_lead_total;
    logic [PW-1:0]                  r_best_pos;
    logic                           r_out_valid;
    logic                           r_found;
    logic [lurb_pkg::INDEX_W-1:0]   r_index;
    lurb_pkg::t_err                 r_err_out;

    logic                           n_have_best;
    lurb_pkg::t_err                 n_worst;
    logic [lurb_pkg::BYTES_W-1:0]   n_lead_used;
    logic [lurb_pkg::TOTAL_W-1:0]   n_lead_total;
    logic [PW-1:0]                  n_best_pos;
    logic                           n_out_valid;
    logic                           n_found;
    logic [lurb_pkg::INDEX_W-1:0]   n_index;
    lurb_pkg::t_err                 n_err_out;

    logic [lurb_pkg::PROD_W-1:0]    b_lhs, b_rhs, p_lhs, p_rhs;
    logic                           less;
    logic                           fire;
    lurb_pkg::t_err                 merged;
    logic [PW-1:0]                  win_pos;
    logic [PW+lurb_pkg::INDEX_W-1:0] wide_pos;

    // Exact compare: candidate used * best total < best used * candidate total
    assign b_lhs = lurb_pkg::fold(i_xb.lhs);
    assign b_rhs = lurb_pkg::fold(i_xb.rhs);
    assign p_lhs = lurb_pkg::fold(i_xp.lhs);
    assign p_rhs = lurb_pkg::fold(i_xp.rhs);
    assign less  = i_use_prev ? (p_lhs < p_rhs) : (b_lhs < b_rhs);

    // Pipeline holds only while a result is pending behind a stalled one
    assign o_advance = !(r_out_valid && i_stall && i_s2_valid && i_s2.last);
    assign fire      = o_advance && i_s2_valid;
    assign o_win     = i_s2_valid && i_s2.cons && (!r_have_best || less);

    assign merged   = (i_s2.err > r_worst) ? i_s2.err : r_worst;
    assign win_pos  = o_win ? i_s2_pos : r_best_pos;
    assign wide_pos = {{lurb_pkg::INDEX_W{1'b0}}, win_pos};

    // Best state, error and result
    always_comb begin
        n_have_best  = r_have_best;
        n_worst      = r_worst;
        n_lead_used  = r_lead_used;
        n_lead_total = r_lead_total;
        n_best_pos   = r_best_pos;
        n_out_valid  = i_stall ? r_out_valid : 1'b0;
        n_found      = r_found;
        n_index      = r_index;
        n_err_out    = r_err_out;
        if (fire) begin
            if (o_win) begin
                n_have_best  = 1'b1;
                n_lead_used  = i_s2.used;
                n_lead_total = i_s2.total;
                n_best_pos   = i_s2_pos;
            end
            n_worst = merged;
            if (i_s2.last) begin
                n_out_valid = 1'b1;
                n_found     = r_have_best || o_win;
                if (r_have_best || o_win) begin
                    n_index   = wide_pos[lurb_pkg::INDEX_W-1:0];
                    n_err_out = lurb_pkg::ERR_NONE;
                end else begin
                    n_index   = '0;
                    n_err_out = merged;
                end
                // run closed: back to the empty state
                n_have_best  = 1'b0;
                n_worst      = lurb_pkg::ERR_NOENT;
                n_lead_used  = '0;
                n_lead_total = lurb_pkg::TOTAL_W'(1);
                n_best_pos   = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_have_best <= 1'b0;
            r_worst     <= lurb_pkg::ERR_NOENT;
            r_out_valid <= 1'b0;
        end else begin
            r_have_best <= n_have_best;
            r_worst     <= n_worst;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_lead_used  <= n_lead_used;
        r_lead_total <= n_lead_total;
        r_best_pos   <= n_best_pos;
        r_found      <= n_found;
        r_index      <= n_index;
        r_err_out    <= n_err_out;
    end

    assign o_lead_used    = r_lead_used;
    assign o_lead_total   = r_lead_total;
    assign o_valid        = r_out_valid;
    assign o_found        = r_found;
    assign o_chosen_index = r_index;
    assign o_error_kind   = r_err_out;

    // Checks
    `LURB_ASSERT_NOW(a_found_no_err, r_out_valid && r_found, r_err_out == lurb_pkg::ERR_NONE)
    `LURB_ASSERT_NOW(a_miss_has_err, r_out_valid && !r_found, r_err_out != lurb_pkg::ERR_NONE)
    `LURB_ASSERT_NEXT(a_run_clears, fire && i_s2.last, !r_have_best && r_worst == lurb_pkg::ERR_NOENT)
    `LURB_ASSERT_NEXT(a_result_held, r_out_valid && i_stall, r_out_valid)
    `LURB_ASSERT_NEXT(a_last_gives_result, fire && i_s2.last, r_out_valid)

endmodule

/* rtl/core/least_used_ratio_branch_select_core.sv */
// An accepted last_branch item reaches o_valid via the partial-product and result registers.
// Throughput: one item per cycle while o_stall is low. Four 32x32 partial products per
// cross product are registered; the next stage sums, compares and updates the running best.
// The input is stalled only while a run result is pending behind a stalled result.
// Reset (i_rst_n low, synchronous) empties the pipeline and clears best, error and position.
// ============================================================================
// least_used_ratio_branch_select_core
// Picks the branch of a run with the lowest used/total fraction, or reports
// the highest-priority error seen when no branch qualifies.
// ============================================================================
module least_used_ratio_branch_select_core #(
    parameter int MAX_BRANCHES = lurb_pkg::MAX_BRANCHES_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_stall,
    input  logic [1:0]                     i_mode,
    input  logic                           i_branch_readonly,
    input  logic                           i_branch_no_create,
    input  logic                           i_path_exists,
    input  logic                           i_stats_ok,
    input  logic                           i_fs_readonly,
    input  logic [lurb_pkg::BYTES_W-1:0]   i_space_used,
    input  logic [lurb_pkg::BYTES_W-1:0]   i_space_avail,
    input  logic [lurb_pkg::BYTES_W-1:0]   i_min_free_space,
    input  logic                           i_last_branch,
    output logic                           o_valid,
    input  logic                           i_stall,
    output logic                           o_found,
    output logic [lurb_pkg::INDEX_W-1:0]   o_chosen_index,
    output logic [1:0]                     o_error_kind
);

    localparam int PW = $clog2(MAX_BRANCHES + 1);

    logic                          advance;
    logic                          f_valid;
    lurb_pkg::t_item               f_item;
    logic [PW-1:0]                 f_pos;
    logic                          s2_valid;
    lurb_pkg::t_item               s2_item;
    logic [PW-1:0]                 s2_pos;
    lurb_pkg::t_xpair              s2_xb;
    lurb_pkg::t_xpair              s2_xp;
    logic                          s2_use_prev;
    logic                          s2_win;
    logic [lurb_pkg::BYTES_W-1:0]  lead_used;
    logic [lurb_pkg::TOTAL_W-1:0]  lead_total;

    assign o_stall = !advance;

    // Input register and filters
    lurb_front #(.MAX_BRANCHES(MAX_BRANCHES)) u_front (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_advance          (advance),
        .i_valid            (i_valid),
        .i_mode             (i_mode),
        .i_branch_readonly  (i_branch_readonly),
        .i_branch_no_create (i_branch_no_create),
        .i_path_exists      (i_path_exists),
        .i_stats_ok         (i_stats_ok),
        .i_fs_readonly      (i_fs_readonly),
        .i_space_used       (i_space_used),
        .i_space_avail      (i_space_avail),
        .i_min_free_space   (i_min_free_space),
        .i_last_branch      (i_last_branch),
        .o_valid            (f_valid),
        .o_item             (f_item),
        .o_pos              (f_pos)
    );

    // Partial products
    lurb_xmul #(.MAX_BRANCHES(MAX_BRANCHES)) u_xmul (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_advance    (advance),
        .i_valid      (f_valid),
        .i_item       (f_item),
        .i_pos        (f_pos),
        .i_lead_used  (lead_used),
        .i_lead_total (lead_total),
        .i_ahead_win  (s2_win),
        .o_valid      (s2_valid),
        .o_item       (s2_item),
        .o_pos        (s2_pos),
        .o_xb         (s2_xb),
        .o_xp         (s2_xp),
        .o_use_prev   (s2_use_prev)
    );

    // Compare, running best and result
    lurb_pick #(.MAX_BRANCHES(MAX_BRANCHES)) u_pick (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_s2_valid     (s2_valid),
        .i_s2           (s2_item),
        .i_s2_pos       (s2_pos),
        .i_xb           (s2_xb),
        .i_xp           (s2_xp),
        .i_use_prev     (s2_use_prev),
        .i_stall        (i_stall),
        .o_advance      (advance),
        .o_win          (s2_win),
        .o_lead_used    (lead_used),
        .o_lead_total   (lead_total),
        .o_valid        (o_valid),
        .o_found        (o_found),
        .o_chosen_index (o_chosen_index),
        .o_error_kind   (o_error_kind)
    );

endmodule

/* tb/sv/testbench.sv */
// ============================================================================
// Least-used ratio branch selector testbench
// Feeds runs of branch status items through the selector and checks every
// run result against a cycle-free model of the filter, error and fraction
// compare rules. The sender works in random bursts and the receiver stalls
// on its own pattern, with one long hold-off that backs the block up.
// ============================================================================
module testbench;

    localparam int          BRANCH_LIMIT  = lurb_pkg::MAX_BRANCHES_DEF;
    localparam int          RANDOM_ITEMS  = 1100;
    localparam int          HOLDOFF_AT    = 400;
    localparam int          HOLDOFF_LEN   = 300;
    localparam logic [1:0]  MODE_SKIP     = 2'd3;   // undefined mode, item ignored
    localparam logic [63:0] BYTES_MAX     = '1;

    // One branch status item as offered to the block
    typedef struct {
        logic [1:0]  mode;
        logic        b_ro;
        logic        b_nc;
        logic        exists;
        logic        st_ok;
        logic        fs_ro;
        logic [63:0] used;
        logic [63:0] avail;
        logic [63:0] minfree;
        logic        last;
    } t_branch_item;

    // One run result
    typedef struct {
        logic       found;
        logic [5:0] index;
        logic [1:0] err;
    } t_run_pick;

    logic                         i_clk = 1'b0;
    logic                         i_rst_n = 1'b0;
    logic                         i_valid = 1'b0;
    logic                         o_stall;
    logic [1:0]                   i_mode = '0;
    logic                         i_branch_readonly = 1'b0;
    logic                         i_branch_no_create = 1'b0;
    logic                         i_path_exists = 1'b0;
    logic                         i_stats_ok = 1'b0;
    logic                         i_fs_readonly = 1'b0;
    logic [lurb_pkg::BYTES_W-1:0] i_space_used = '0;
    logic [lurb_pkg::BYTES_W-1:0] i_space_avail = '0;
    logic [lurb_pkg::BYTES_W-1:0] i_min_free_space = '0;
    logic                         i_last_branch = 1'b0;
    logic                         o_valid;
    logic                         i_stall = 1'b0;
    logic                         o_found;
    logic [lurb_pkg::INDEX_W-1:0] o_chosen_index;
    logic [1:0]                   o_error_kind;

    least_used_ratio_branch_select_core #(
        .MAX_BRANCHES (BRANCH_LIMIT)
    ) u_dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_valid            (i_valid),
        .o_stall            (o_stall),
        .i_mode             (i_mode),
        .i_branch_readonly  (i_branch_readonly),
        .i_branch_no_create (i_branch_no_create),
        .i_path_exists      (i_path_exists),
        .i_stats_ok         (i_stats_ok),
        .i_fs_readonly      (i_fs_readonly),
        .i_space_used       (i_space_used),
        .i_space_avail      (i_space_avail),
        .i_min_free_space   (i_min_free_space),
        .i_last_branch      (i_last_branch),
        .o_valid            (o_valid),
        .i_stall            (i_stall),
        .o_found            (o_found),
        .o_chosen_index     (o_chosen_index),
        .o_error_kind       (o_error_kind)
    );

    // Clock
    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Reset, held low at the start and then released
    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    // Limit on the whole run
    initial begin
        #3000000;
        $display("Simulation FAILED");
        $finish;
    end

    t_branch_item branch_feed[$];
    t_run_pick    pending_picks[$];
    int           fail_count = 0;

    // Selection state of the model
    logic [63:0]     sel_lead_used;
    logic [64:0]     sel_lead_total;
    logic [5:0]      sel_best_pos;
    logic            sel_have_best;
    lurb_pkg::t_err  sel_worst_err;
    logic [6:0]      sel_item_pos;

    task automatic note_failure(input string msg);
        fail_count++;
        if (fail_count <= 10) begin
            $display("%s", msg);
        end
    endtask

    task automatic clear_selection();
        sel_lead_used  = '0;
        sel_lead_total = 65'd1;
        sel_best_pos   = '0;
        sel_have_best  = 1'b0;
        sel_worst_err  = lurb_pkg::ERR_NOENT;
        sel_item_pos   = '0;
    endtask

    // Filter one accepted item, update the running best, close the run on last
    task automatic predict_selection(input t_branch_item it);
        logic [64:0]     tot;
        logic [63:0]     u;
        logic [128:0]    lhs;
        logic [128:0]    rhs;
        logic            qualifies;
        lurb_pkg::t_err  err_seen;
        t_run_pick       pick;
        qualifies = 1'b0;
        err_seen  = lurb_pkg::ERR_NONE;
        if (sel_item_pos < BRANCH_LIMIT) begin
            case (it.mode)
                lurb_pkg::MODE_ACTION: begin
                    if (it.b_ro)         err_seen = lurb_pkg::ERR_ROFS;
                    else if (!it.exists) err_seen = lurb_pkg::ERR_NOENT;
                    else if (!it.st_ok)  err_seen = lurb_pkg::ERR_NOENT;
                    else if (it.fs_ro)   err_seen = lurb_pkg::ERR_ROFS;
                    else                 qualifies = 1'b1;
                end
                lurb_pkg::MODE_SEARCH: begin
                    qualifies = it.exists && it.st_ok;
                end
                lurb_pkg::MODE_CREATE: begin
                    if (it.b_ro || it.b_nc)         err_seen = lurb_pkg::ERR_ROFS;
                    else if (!it.st_ok)             err_seen = lurb_pkg::ERR_NOENT;
                    else if (it.fs_ro)              err_seen = lurb_pkg::ERR_ROFS;
                    else if (it.avail < it.minfree) err_seen = lurb_pkg::ERR_NOSPC;
                    else                            qualifies = 1'b1;
                end
                default: ;
            endcase
            if (err_seen > sel_worst_err) begin
                sel_worst_err = err_seen;
            end
            // Exact cross-multiplied fraction compare; a zero total reads as 0/1
            if (qualifies) begin
                tot = {1'b0, it.used} + {1'b0, it.avail};
                u   = it.used;
                if (tot == '0) begin
                    u   = '0;
                    tot = 65'd1;
                end
                lhs = 129'(u) * 129'(sel_lead_total);
                rhs = 129'(sel_lead_used) * 129'(tot);
                if (!sel_have_best || lhs < rhs) begin
                    sel_lead_used  = u;
                    sel_lead_total = tot;
                    sel_best_pos   = sel_item_pos[5:0];
                    sel_have_best  = 1'b1;
                end
            end
            sel_item_pos = sel_item_pos + 7'd1;
        end
        if (it.last) begin
            if (sel_have_best) begin
                pick.found = 1'b1;
                pick.index = sel_best_pos;
                pick.err   = lurb_pkg::ERR_NONE;
            end else begin
                pick.found = 1'b0;
                pick.index = '0;
                pick.err   = sel_worst_err;
            end
            pending_picks.insert(pending_picks.size(), pick);
            clear_selection();
        end
    endtask

    // Flags in order: branch read-only, no-create, path exists, stats ok, fs read-only
    function automatic t_branch_item make_item(input logic [1:0] mode,
                                               input logic [4:0] flags,
                                               input logic [63:0] used,
                                               input logic [63:0] avail,
                                               input logic [63:0] minfree,
                                               input logic last);
        t_branch_item it;
        it.mode    = mode;
        it.b_ro    = flags[4];
        it.b_nc    = flags[3];
        it.exists  = flags[2];
        it.st_ok   = flags[1];
        it.fs_ro   = flags[0];
        it.used    = used;
        it.avail   = avail;
        it.minfree = minfree;
        it.last    = last;
        return it;
    endfunction

    task automatic add_item(input t_branch_item it);
        branch_feed.insert(branch_feed.size(), it);
    endtask

    // Byte counts spread over zero, the top, small values, powers of two, just under the top and noise
    function automatic logic [63:0] rand_bytes();
        logic [63:0] v;
        case ($urandom_range(0, 9))
            0:       v = '0;
            1:       v = BYTES_MAX;
            2:       v = 64'($urandom_range(0, 1000));
            3:       v = 64'd1 << $urandom_range(0, 63);
            4:       v = BYTES_MAX - 64'($urandom_range(0, 1000));
            default: v = {$urandom, $urandom};
        endcase
        return v;
    endfunction

    // Sender: bursts of items with random gaps, payload held while stalled
    t_branch_item drv_item;
    int           burst_left = 1;
    int           gap_left = 0;
    int           accepted_count = 0;
    logic         holdoff_req = 1'b0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && !o_stall) begin
                predict_selection(drv_item);
                accepted_count++;
                if (accepted_count == HOLDOFF_AT) begin
                    holdoff_req <= 1'b1;
                end
            end
            if (!(i_valid && o_stall)) begin
                if (gap_left > 0) begin
                    gap_left--;
                    i_valid <= 1'b0;
                end else if (branch_feed.size() > 0) begin
                    drv_item            = branch_feed.pop_front();
                    i_valid            <= 1'b1;
                    i_mode             <= drv_item.mode;
                    i_branch_readonly  <= drv_item.b_ro;
                    i_branch_no_create <= drv_item.b_nc;
                    i_path_exists      <= drv_item.exists;
                    i_stats_ok         <= drv_item.st_ok;
                    i_fs_readonly      <= drv_item.fs_ro;
                    i_space_used       <= drv_item.used;
                    i_space_avail      <= drv_item.avail;
                    i_min_free_space   <= drv_item.minfree;
                    i_last_branch      <= drv_item.last;
                    if (burst_left <= 1) begin
                        burst_left = $urandom_range(1, 40);
                        gap_left   = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 6);
                    end else begin
                        burst_left--;
                    end
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver stall pattern, with one long hold-off once the sender is well under way
    int   stall_style = 0;
    int   stall_phase_left = 0;
    int   holdoff_cnt = 0;
    logic holdoff_done = 1'b0;
    logic stall_toggle = 1'b0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else if (holdoff_req && !holdoff_done) begin
            i_stall <= 1'b1;
            holdoff_cnt++;
            if (holdoff_cnt >= HOLDOFF_LEN) begin
                holdoff_done = 1'b1;
            end
        end else begin
            if (stall_phase_left == 0) begin
                stall_style      = $urandom_range(0, 3);
                stall_phase_left = $urandom_range(16, 96);
            end else begin
                stall_phase_left--;
            end
            stall_toggle = ~stall_toggle;
            case (stall_style)
                0:       i_stall <= 1'b0;
                1:       i_stall <= ($urandom_range(0, 7) == 0);
                2:       i_stall <= ($urandom_range(0, 1) == 0);
                default: i_stall <= stall_toggle;
            endcase
        end
    end

    // Result checker
    t_run_pick want;

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_picks.size() == 0) begin
                note_failure($sformatf("unexpected result: found=%0d index=%0d err=%0d",
                                       o_found, o_chosen_index, o_error_kind));
            end else begin
                want = pending_picks.pop_front();
                if (o_found !== want.found || o_chosen_index !== want.index ||
                    o_error_kind !== want.err) begin
                    note_failure($sformatf(
                        "mismatch: exp found=%0d idx=%0d err=%0d, got found=%0d idx=%0d err=%0d",
                        want.found, want.index, want.err,
                        o_found, o_chosen_index, o_error_kind));
                end
            end
        end
    end

    // Stimulus and end of run
    initial begin
        t_branch_item it;
        logic [63:0]  prev_used;
        logic [63:0]  prev_avail;
        logic [63:0]  u;
        logic [63:0]  a;
        logic [63:0]  mf;
        logic [1:0]   md;
        int           run_len;
        int           drain;
        bit           first_run;

        clear_selection();

        // Zero used and zero avail on a lone item
        add_item(make_item(lurb_pkg::MODE_ACTION, 5'b00110, '0, '0, '0, 1'b1));
        // Action filters only: read-only wins over not found
        add_item(make_item(lurb_pkg::MODE_ACTION, 5'b10110, 64'd5, 64'd5, '0, 1'b0));
        add_item(make_item(lurb_pkg::MODE_ACTION, 5'b00010, 64'd5, 64'd5, '0, 1'b0));
        add_item(make_item(lurb_pkg::MODE_ACTION, 5'b00100, 64'd5, 64'd5, '0, 1'b0));
        add_item(make_item(lurb_pkg::MODE_ACTION, 5'b00111, 64'd5, 64'd5, '0, 1'b1));
        // Search skips silently; undefined mode is ignored; nothing left means not found
        add_item(make_item(lurb_pkg::MODE_SEARCH, 5'b11011, 64'd1, 64'd2, '0, 1'b0));
        add_item(make_item(MODE_SKIP, 5'b11111, 64'd1, 64'd2, '0, 1'b0));
        add_item(make_item(lurb_pkg::MODE_SEARCH, 5'b00100, 64'd1, 64'd2, '0, 1'b1));
        // Create filters: no-create, no space, missing stats
        add_item(make_item(lurb_pkg::MODE_CREATE, 5'b01110, 64'd1, 64'd2, '0, 1'b0));
        add_item(make_item(lurb_pkg::MODE_CREATE, 5'b00110, 64'd1, 64'd9, 64'd10, 1'b0));
        add_item(make_item(lurb_pkg::MODE_CREATE, 5'b00100, 64'd1, 64'd2, '0, 1'b1));
        // Equal fractions keep the first, including a total that carries into bit 64
        add_item(make_item(lurb_pkg::MODE_ACTION, 5'b00110, 64'd1, 64'd1, '0, 1'b0));
        add_item(make_item(lurb_pkg::MODE_SEARCH, 5'b00110, 64'd2, 64'd2, '0, 1'b0));
        add_item(make_item(lurb_pkg::MODE_CREATE, 5'b00010, BYTES_MAX, BYTES_MAX,
                           BYTES_MAX, 1'b1));
        // Full branch, then an empty one with a huge total, then a zero-total one
        add_item(make_item(lurb_pkg::MODE_ACTION, 5'b00110, BYTES_MAX, '0, '0, 1'b0));
        add_item(make_item(lurb_pkg::MODE_SEARCH, 5'b00110, '0, BYTES_MAX, '0, 1'b0));
        add_item(make_item(lurb_pkg::MODE_ACTION, 5'b00110, '0, '0, '0, 1'b1));
        // Later smaller fraction replaces; create with free space exactly at the minimum
        add_item(make_item(lurb_pkg::MODE_CREATE, 5'b00110, 64'd3, 64'd1, 64'd1, 1'b0));
        add_item(make_item(lurb_pkg::MODE_CREATE, 5'b00110, BYTES_MAX - 64'd1,
                           BYTES_MAX, BYTES_MAX, 1'b0));
        add_item(make_item(lurb_pkg::MODE_ACTION, 5'b00110, 64'd1, 64'd3, '0, 1'b1));
        // Errors mixed with a qualifying branch
        add_item(make_item(lurb_pkg::MODE_CREATE, 5'b00110, 64'd1, '0, BYTES_MAX, 1'b0));
        add_item(make_item(lurb_pkg::MODE_CREATE, 5'b10111, 64'd1, '0, '0, 1'b0));
        add_item(make_item(lurb_pkg::MODE_SEARCH, 5'b00110, 64'd7, 64'd1, '0, 1'b1));

        // Random runs: mostly well-formed with a few faults, some long ones past the limit
        prev_used  = 64'd1;
        prev_avail = 64'd1;
        first_run  = 1'b1;
        while (branch_feed.size() < RANDOM_ITEMS + 23) begin
            if (first_run || $urandom_range(0, 19) == 0) begin
                run_len = $urandom_range(BRANCH_LIMIT - 4, BRANCH_LIMIT + 8);
            end else begin
                run_len = $urandom_range(1, 8);
            end
            first_run = 1'b0;
            md = 2'($urandom_range(0, 2));
            for (int k = 0; k < run_len; k++) begin
                if ($urandom_range(0, 3) == 0) begin
                    md = ($urandom_range(0, 19) == 0) ? MODE_SKIP : 2'($urandom_range(0, 2));
                end
                if ($urandom_range(0, 7) == 0) begin
                    u = prev_used;
                    a = prev_avail;
                    if ($urandom_range(0, 1) == 0 && u[63] == 1'b0 && a[63] == 1'b0) begin
                        u = u << 1;
                        a = a << 1;
                    end
                end else begin
                    u = rand_bytes();
                    a = rand_bytes();
                end
                case ($urandom_range(0, 3))
                    0:       mf = a;
                    1:       mf = (a == BYTES_MAX) ? a : a + 64'd1;
                    2:       mf = rand_bytes();
                    default: mf = (a == '0) ? a : 64'($urandom) % a;
                endcase
                if ($urandom_range(0, 9) == 0) begin
                    it = make_item(md, 5'($urandom), u, a, mf, 1'b0);
                end else begin
                    it = make_item(md, {$urandom_range(0, 9) == 0, $urandom_range(0, 9) == 0,
                                        $urandom_range(0, 9) != 0, $urandom_range(0, 9) != 0,
                                        $urandom_range(0, 9) == 0}, u, a, mf, 1'b0);
                end
                it.last = (k == run_len - 1);
                add_item(it);
                prev_used  = u;
                prev_avail = a;
            end
        end

        // Wait for the feed to drain, then for the outstanding results
        wait (i_rst_n);
        while (branch_feed.size() != 0 || i_valid) begin
            @(posedge i_clk);
        end
        drain = 0;
        while (pending_picks.size() != 0 && drain < 5000) begin
            @(posedge i_clk);
            drain++;
        end
        repeat (8) @(posedge i_clk);
        if (pending_picks.size() != 0) begin
            note_failure($sformatf("%0d results never arrived", pending_picks.size()));
        end
        if (fail_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
